// ===== hw/rtl/pcet_pkg.sv =====
`timescale 1ns / 1ps

package pcet_pkg;

    // Default depth of the pair table.
    localparam int TABLE_ENTRIES_DEFAULT = 256;

    localparam int KEY_W = 64;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_ENTER = 2'd1,
        EV_STAY  = 2'd2,
        EV_EXIT  = 2'd3
    } contact_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_EMIT
    } state_t;

    // One collider pair as it arrives on the input channel.
    typedef struct packed {
        logic        [31:0] left_id;
        logic        [31:0] right_ident;
        logic signed [23:0] left_cx;
        logic signed [23:0] left_cy;
        logic        [22:0] left_w;
        logic        [22:0] left_h;
        logic signed [23:0] right_cx;
        logic signed [23:0] right_cy;
        logic        [22:0] right_w;
        logic        [22:0] right_h;
        logic               left_dying;
        logic               right_dying;
    } pair_t;

    // One result on the output channel.
    typedef struct packed {
        contact_t contact_event;
        logic     table_full;
    } result_t;

    // One entry of the pair table.
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             touching;
    } entry_t;

endpackage

// ===== hw/rtl/pcet_overlap.sv =====
`timescale 1ns / 1ps

// Box overlap test on both axes, registered when a pair is taken in.
module pcet_overlap
(
    input  logic          clk,
    input  logic          load,
    input  pcet_pkg::pair_t pair,
    output logic          overlap_reg
);

    logic overlap_next;

    // True when 2*|cb - ca| <= sa + sb.
    function automatic logic axis_hit(
        input logic [23:0] ca,
        input logic [23:0] cb,
        input logic [22:0] sa,
        input logic [22:0] sb
    );
        logic [24:0] diff;
        logic [24:0] mag;
        logic [25:0] twice;
        logic [25:0] total;
        diff  = {cb[23], cb} - {ca[23], ca};
        mag   = diff[24] ? (~diff + 25'd1) : diff;
        twice = {mag, 1'b0};
        total = {3'b000, sa} + {3'b000, sb};
        return twice <= total;
    endfunction

    assign overlap_next = axis_hit(pair.left_cx, pair.right_cx, pair.left_w, pair.right_w)
                       && axis_hit(pair.left_cy, pair.right_cy, pair.left_h, pair.right_h);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            overlap_reg <= overlap_next;
        end
    end

endmodule

// ===== hw/rtl/pcet_table.sv =====
`timescale 1ns / 1ps

// Pair table: one write port and one read port with registered read data.
module pcet_table
#(
    parameter int TABLE_ENTRIES = pcet_pkg::TABLE_ENTRIES_DEFAULT,
    localparam int IW = $clog2(TABLE_ENTRIES)
)
(
    input  logic             clk,
    input  logic             rd_en,
    input  logic [IW-1:0]    rd_addr,
    output pcet_pkg::entry_t rd_data,
    input  logic             wr_en,
    input  logic [IW-1:0]    wr_addr,
    input  pcet_pkg::entry_t wr_data
);

    pcet_pkg::entry_t mem [TABLE_ENTRIES];
    pcet_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/pair_collision_event_tracker_unit.sv =====
`timescale 1ns / 1ps

// Pair contact tracker. Each transfer on the pair channel carries two collider
// ids, two axis-aligned boxes and two pending-removal flags; each produces
// exactly one transfer on the event channel with enter, stay, exit or none and
// a table-full flag. Pairs are remembered by their 64-bit key (left id above
// right id) in a table of TABLE_ENTRIES entries held in one single-port-read
// memory. One pair is handled at a time: the key is compared against the
// stored entries one per cycle through the memory read port. A search that
// ends on a hit or a free entry writes the entry back, and then the result
// is loaded into the output register once the event side has room. The next
// pair is taken in the cycle after the result is loaded into the output
// register, even if the downstream side has not yet taken it. A new result
// waits until the previous one has left the output register. When the table
// is full an unseen pair is reported as none with table_full set and is not
// stored.
module pair_collision_event_tracker_unit
#(
    parameter int TABLE_ENTRIES = pcet_pkg::TABLE_ENTRIES_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              pair_valid,
    output logic              pair_stall,
    input  pcet_pkg::pair_t   pair_data,

    output logic              event_valid,
    input  logic              event_stall,
    output pcet_pkg::result_t event_data
);

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    pcet_pkg::state_t  state_reg, state_next;

    // Search position: the next entry to read, and the entry whose data
    // arrives from the memory in the current cycle.
    logic [CW-1:0]     issue_reg, issue_next;
    logic              pend_reg, pend_next;
    logic [IW-1:0]     pend_idx_reg, pend_idx_next;

    // Number of valid entries; entries 0 .. used-1 hold keys.
    logic [CW-1:0]     used_reg, used_next;

    // Per-pair working registers.
    logic [IW-1:0]     slot_reg, slot_next;
    logic              touch_reg, touch_next;
    logic              insert_reg, insert_next;
    logic [pcet_pkg::KEY_W-1:0] key_reg, key_next;
    logic              dying_reg, dying_next;
    pcet_pkg::result_t res_reg, res_next;

    logic              out_valid_reg, out_valid_next;
    pcet_pkg::result_t out_data_reg, out_data_next;

    logic              accept;
    logic              overlap;

    logic              rd_en;
    logic [IW-1:0]     rd_addr;
    pcet_pkg::entry_t  rd_data;
    logic              wr_en;
    pcet_pkg::entry_t  wr_data;
    logic              hit;
    logic              new_touch;
    pcet_pkg::contact_t new_event;

    assign pair_stall  = (state_reg != pcet_pkg::ST_IDLE);
    assign accept      = pair_valid && !pair_stall;
    assign event_valid = out_valid_reg;
    assign event_data  = out_data_reg;

    pcet_overlap u_overlap
    (
        .clk         (clk),
        .load        (accept),
        .pair        (pair_data),
        .overlap_reg (overlap)
    );

    pcet_table
    #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    )
    u_table
    (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (slot_reg),
        .wr_data (wr_data)
    );

    assign hit = pend_reg && (rd_data.key == key_reg);

    // Event rules: a dying member always ends the contact, and an overlap
    // that starts while a member is dying is reported as exit.
    always_comb
    begin
        new_touch = 1'b0;
        new_event = pcet_pkg::EV_NONE;
        if (overlap)
        begin
            if (touch_reg)
            begin
                if (dying_reg)
                begin
                    new_event = pcet_pkg::EV_EXIT;
                end
                else
                begin
                    new_event = pcet_pkg::EV_STAY;
                    new_touch = 1'b1;
                end
            end
            else if (!dying_reg)
            begin
                new_event = pcet_pkg::EV_ENTER;
                new_touch = 1'b1;
            end
            else
            begin
                new_event = pcet_pkg::EV_EXIT;
            end
        end
        else if (touch_reg)
        begin
            new_event = pcet_pkg::EV_EXIT;
        end
    end

    assign wr_data.key      = key_reg;
    assign wr_data.touching = new_touch;

    always_comb
    begin
        state_next     = state_reg;
        issue_next     = issue_reg;
        pend_next      = 1'b0;
        pend_idx_next  = pend_idx_reg;
        used_next      = used_reg;
        slot_next      = slot_reg;
        touch_next     = touch_reg;
        insert_next    = insert_reg;
        key_next       = key_reg;
        dying_next     = dying_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && event_stall;
        out_data_next  = out_data_reg;
        rd_en          = 1'b0;
        rd_addr        = issue_reg[IW-1:0];
        wr_en          = 1'b0;

        case (state_reg)
            pcet_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    key_next   = {pair_data.left_id, pair_data.right_ident};
                    dying_next = pair_data.left_dying | pair_data.right_dying;
                    issue_next = '0;
                    state_next = pcet_pkg::ST_SCAN;
                end
            end

            pcet_pkg::ST_SCAN:
            begin
                if (hit)
                begin
                    slot_next   = pend_idx_reg;
                    touch_next  = rd_data.touching;
                    insert_next = 1'b0;
                    state_next  = pcet_pkg::ST_UPDATE;
                end
                else if (issue_reg < used_reg)
                begin
                    rd_en         = 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = issue_reg[IW-1:0];
                    issue_next    = issue_reg + CW'(1);
                end
                else if (used_reg == CW'(TABLE_ENTRIES))
                begin
                    // Unseen key and no free entry.
                    res_next.contact_event = pcet_pkg::EV_NONE;
                    res_next.table_full    = 1'b1;
                    state_next             = pcet_pkg::ST_EMIT;
                end
                else
                begin
                    slot_next   = used_reg[IW-1:0];
                    touch_next  = 1'b0;
                    insert_next = 1'b1;
                    state_next  = pcet_pkg::ST_UPDATE;
                end
            end

            pcet_pkg::ST_UPDATE:
            begin
                wr_en = 1'b1;
                if (insert_reg)
                begin
                    used_next = used_reg + CW'(1);
                end
                res_next.contact_event = new_event;
                res_next.table_full    = 1'b0;
                state_next             = pcet_pkg::ST_EMIT;
            end

            pcet_pkg::ST_EMIT:
            begin
                if (!out_valid_reg || !event_stall)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = pcet_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = pcet_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pcet_pkg::ST_IDLE;
            issue_reg     <= '0;
            pend_reg      <= 1'b0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_reg     <= issue_next;
            pend_reg      <= pend_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg <= pend_idx_next;
        slot_reg     <= slot_next;
        touch_reg    <= touch_next;
        insert_reg   <= insert_next;
        key_reg      <= key_next;
        dying_reg    <= dying_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

endmodule
